>>> rtl/core/cpdt_pkg.sv
// Types and constants shared by the curve peak/dip tracker core.
// No dependencies.
`default_nettype none

package cpdt_pkg;

  localparam int unsigned ENERGY_W = 32;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned N_FOUND  = 4;

  // Search stage, one-hot
  typedef enum logic [4:0] {
    STG_PEAK1 = 5'b00001,
    STG_DIP1  = 5'b00010,
    STG_PEAK2 = 5'b00100,
    STG_DIP2  = 5'b01000,
    STG_DONE  = 5'b10000
  } stage_e;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic [VALUE_W-1:0]  cross_section;
    logic                last_sample;
  } in_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] first_peak_energy;
    logic                first_peak_found;
    logic [ENERGY_W-1:0] first_dip_energy;
    logic                first_dip_found;
    logic [ENERGY_W-1:0] second_peak_energy;
    logic                second_peak_found;
    logic [ENERGY_W-1:0] second_dip_energy;
    logic                second_dip_found;
  } out_t;

  typedef struct packed {
    stage_e                            stage;
    logic [VALUE_W-1:0]                ext_value;
    logic [ENERGY_W-1:0]               ext_energy;
    logic [N_FOUND-1:0][ENERGY_W-1:0]  found;
  } state_t;

  localparam state_t STATE_RESET = '{
    stage:      STG_PEAK1,
    ext_value:  '0,
    ext_energy: '0,
    found:      '0
  };

endpackage

`default_nettype wire

>>> rtl/core/cpdt_step.sv
// Combinational per-item update of the tracker state and result assembly.
// Depends on cpdt_pkg.
`default_nettype none

module cpdt_step (
  input  cpdt_pkg::state_t state_i,
  input  cpdt_pkg::in_t    item_i,
  output cpdt_pkg::state_t state_o,
  output cpdt_pkg::out_t   result_o
);
  import cpdt_pkg::*;

  logic        active;
  logic        seek_peak;
  logic        keep;
  logic [1:0]  idx;
  stage_e      stage_next;
  logic [3:0]  found_flag;

  always_comb begin
    active     = 1'b1;
    seek_peak  = 1'b0;
    idx        = 2'd0;
    stage_next = state_i.stage;
    unique case (state_i.stage)
      STG_PEAK1: begin
        seek_peak  = 1'b1;
        idx        = 2'd0;
        stage_next = STG_DIP1;
      end
      STG_DIP1: begin
        idx        = 2'd1;
        stage_next = STG_PEAK2;
      end
      STG_PEAK2: begin
        seek_peak  = 1'b1;
        idx        = 2'd2;
        stage_next = STG_DIP2;
      end
      STG_DIP2: begin
        idx        = 2'd3;
        stage_next = STG_DONE;
      end
      default: begin
        active = 1'b0;
      end
    endcase

    // equal values continue either search
    keep = seek_peak ? (item_i.cross_section >= state_i.ext_value)
                     : (item_i.cross_section <= state_i.ext_value);

    state_o = state_i;
    if (active) begin
      if (!keep) begin
        state_o.found[idx] = state_i.ext_energy;
        state_o.stage      = stage_next;
      end
      // continuing search, or the next search starts at this sample
      if (state_o.stage != STG_DONE) begin
        state_o.ext_value  = item_i.cross_section;
        state_o.ext_energy = item_i.energy;
      end
    end
  end

  always_comb begin
    unique case (state_o.stage)
      STG_PEAK1: found_flag = 4'b0000;
      STG_DIP1:  found_flag = 4'b0001;
      STG_PEAK2: found_flag = 4'b0011;
      STG_DIP2:  found_flag = 4'b0111;
      default:   found_flag = 4'b1111;
    endcase
  end

  assign result_o.first_peak_energy  = found_flag[0] ? state_o.found[0] : '0;
  assign result_o.first_peak_found   = found_flag[0];
  assign result_o.first_dip_energy   = found_flag[1] ? state_o.found[1] : '0;
  assign result_o.first_dip_found    = found_flag[1];
  assign result_o.second_peak_energy = found_flag[2] ? state_o.found[2] : '0;
  assign result_o.second_peak_found  = found_flag[2];
  assign result_o.second_dip_energy  = found_flag[3] ? state_o.found[3] : '0;
  assign result_o.second_dip_found   = found_flag[3];

endmodule

`default_nettype wire

>>> rtl/core/curve_peak_dip_tracker_core.sv
// Top level of the curve peak/dip tracker: state registers, result register
// and handshakes. Depends on cpdt_pkg and cpdt_step.
//
// Takes one curve sample per clock and tracks the first and second peak and
// dip energies. A result item is produced only for a sample marked as last;
// it appears in the result register the cycle after that sample is taken,
// and the tracker is back in its reset state for the next curve at once.
// Samples that are not last are taken every cycle regardless of the output
// side; a last sample waits only while an earlier result is still held in
// the result register by a stall, since that single register is the only
// result storage. Sustained rate: one sample per cycle.
`default_nettype none

module curve_peak_dip_tracker_core (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  cpdt_pkg::in_t     in_data_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output cpdt_pkg::out_t    out_data_o
);
  import cpdt_pkg::*;

  state_t state_q, state_d, state_step;
  out_t   result;
  out_t   out_data_q;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;
  logic   emit;

  cpdt_step u_step (
    .state_i  (state_q),
    .item_i   (in_data_i),
    .state_o  (state_step),
    .result_o (result)
  );

  assign in_stall_o = out_valid_q & out_stall_i & in_data_i.last_sample;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign emit       = in_acc & in_data_i.last_sample;

  always_comb begin
    state_d = state_q;
    if (in_acc) begin
      state_d = in_data_i.last_sample ? STATE_RESET : state_step;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a last sample always yields a result on the next cycle
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_o)
    else $error("last sample did not produce a result");

  // the curve state is cleared after a last sample
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (state_q == STATE_RESET))
    else $error("state not cleared after last sample");

  // stages are found in order
  a_found_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((!out_data_o.first_dip_found || out_data_o.first_peak_found) &&
                     (!out_data_o.second_peak_found || out_data_o.first_dip_found) &&
                     (!out_data_o.second_dip_found || out_data_o.second_peak_found)))
    else $error("found flags out of order");

endmodule

`default_nettype wire
